[design/sha256_message_hasher_assert.svh]
// Assertion macros shared by the hasher RTL.
// Each macro expects clk_i and rst_ni in the including module's scope.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SHAMH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHAMH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/shamh_pkg.sv]
// Shared types, constants and round functions of the SHA-256 hasher.
// Used by shamh_core and sha256_message_hasher; depends on nothing.
`timescale 1ns / 1ps

package shamh_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned NumCv = 8;
  localparam int unsigned NumWin = 16;
  localparam int unsigned CountW = 61;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] PadLenPos = 6'd56;
  localparam logic [5:0] LastPos = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [2:0] LastWordIdx = 3'd7;

  localparam logic [WordW-1:0] ShaIv [NumCv] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Commands from the byte sequencer to the compression unit.
  typedef struct packed {
    logic load;    // shift one packed word into the schedule window
    logic start;   // begin a compression on the window
    logic rotate;  // advance the chaining value by one word for readout
    logic reinit;  // reload the initial hash value
  } core_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

  typedef enum logic [1:0] {
    CoreIdle,
    CoreRound,
    CoreAdd
  } core_state_e;

  typedef enum logic [2:0] {
    StIdle,
    StComp,
    StPadMark,
    StPadZero,
    StPadLen,
    StOut
  } seq_state_e;

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

[design/shamh_core.sv]
// SHA-256 compression unit: schedule window, working words, one round per cycle.
// Depends on shamh_pkg.
`timescale 1ns / 1ps

module shamh_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  shamh_pkg::core_cmd_t             cmd_i,
  input  logic [shamh_pkg::WordW-1:0]      word_i,
  output shamh_pkg::core_status_t          status_o,
  output logic [shamh_pkg::WordW-1:0]      digest_o
);
  import shamh_pkg::*;

  core_state_e       st_q, st_d;
  logic [5:0]        rnd_q, rnd_d;
  logic [WordW-1:0]  win_q [NumWin];
  logic [WordW-1:0]  wk_q [NumCv];
  logic [WordW-1:0]  cv_q [NumCv];
  logic [WordW-1:0]  sched_new;
  logic [WordW-1:0]  t1, t2, ch, maj;

  // Window holds W[t..t+15]; the oldest word sits at index 0.
  assign sched_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];

  assign ch  = (wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]);
  assign maj = (wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]);
  assign t1  = wk_q[7] + big_sigma1(wk_q[4]) + ch + RoundK[rnd_q] + win_q[0];
  assign t2  = big_sigma0(wk_q[0]) + maj;

  always_comb begin
    st_d = st_q;
    case (st_q)
      CoreIdle:  if (cmd_i.start) st_d = CoreRound;
      CoreRound: if (rnd_q == LastRound) st_d = CoreAdd;
      CoreAdd:   st_d = CoreIdle;
      default:   st_d = CoreIdle;
    endcase
  end

  always_comb begin
    rnd_d = rnd_q;
    status_o.busy = 1'b1;
    status_o.done = 1'b0;
    case (st_q)
      CoreIdle: begin
        status_o.busy = 1'b0;
        rnd_d = '0;
      end
      CoreRound: rnd_d = rnd_q + 6'd1;
      CoreAdd:   status_o.done = 1'b1;
      default:   status_o.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= CoreIdle;
      rnd_q <= '0;
    end else begin
      st_q  <= st_d;
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load || st_q == CoreRound) begin
      for (int i = 0; i < NumWin - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[NumWin-1] <= cmd_i.load ? word_i : sched_new;
    end
    if (cmd_i.start) begin
      wk_q <= cv_q;
    end else if (st_q == CoreRound) begin
      wk_q[7] <= wk_q[6];
      wk_q[6] <= wk_q[5];
      wk_q[5] <= wk_q[4];
      wk_q[4] <= wk_q[3] + t1;
      wk_q[3] <= wk_q[2];
      wk_q[2] <= wk_q[1];
      wk_q[1] <= wk_q[0];
      wk_q[0] <= t1 + t2;
    end
  end

  // Chaining value: fold in the working words, rotate for readout, reload the IV.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= ShaIv;
    end else if (cmd_i.reinit) begin
      cv_q <= ShaIv;
    end else if (st_q == CoreAdd) begin
      for (int i = 0; i < NumCv; i++) begin
        cv_q[i] <= cv_q[i] + wk_q[i];
      end
    end else if (cmd_i.rotate) begin
      for (int i = 0; i < NumCv - 1; i++) begin
        cv_q[i] <= cv_q[i+1];
      end
      cv_q[NumCv-1] <= cv_q[0];
    end
  end

  assign digest_o = cv_q[0];

endmodule

[design/sha256_message_hasher.sv]
// SHA-256 message hasher top level: byte packer, padding sequencer, digest readout.
// Depends on shamh_pkg, shamh_core and sha256_message_hasher_assert.svh.
//
// Usage: feed the message one request at a time on the s_axis side; tdata is
// the byte, tuser says whether the byte is real, tlast ends the message (an
// end request with tuser low adds no byte, so an empty message is legal).
// Bytes are taken one per cycle while a 64-byte block fills. The request that
// completes a block starts a compression: 64 rounds at one per cycle on the
// shared round unit, then a fold into the chaining value; s_axis_tready_o
// stays low until the fold is done. At message end the sequencer appends
// 0x80, zeros up to byte 56 and the 64-bit bit length, one byte per cycle
// outside compressions, with one or two more compressions; then eight digest
// requests leave on m_axis, word 0 first, tuser carrying the word index and
// tlast on word 7. A stalled receiver holds the current word and blocks new
// input. Reset loads the initial hash value and clears the byte count and
// block position.
`timescale 1ns / 1ps
`include "sha256_message_hasher_assert.svh"

module sha256_message_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] message_byte
  input  logic        s_axis_tuser_i,   // [0] carries_byte
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o    // last_word
);
  import shamh_pkg::*;

  seq_state_e         st_q, st_d, ret_q, ret_d;
  logic [5:0]         pos_q;
  logic [23:0]        acc_q;
  logic [CountW-1:0]  cnt_q;
  logic [2:0]         len_q;
  logic [2:0]         oidx_q;
  logic               s_fire, m_fire, msg_done;
  logic               put_en;
  logic [7:0]         put_byte;
  logic [63:0]        bit_len;
  logic [7:0]         len_byte;
  core_cmd_t          cmd;
  core_status_t       cstat;
  logic [WordW-1:0]   digest;

  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire   = m_axis_tvalid_o && m_axis_tready_i;
  assign msg_done = m_fire && (oidx_q == LastWordIdx);

  // Length bytes go out most significant first.
  assign bit_len  = {cnt_q, 3'b000};
  assign len_byte = bit_len[{~len_q, 3'b000} +: 8];

  // Next state, including where to resume after a compression.
  always_comb begin
    st_d  = st_q;
    ret_d = ret_q;
    case (st_q)
      StIdle: begin
        if (s_fire) begin
          if (s_axis_tuser_i && pos_q == LastPos) begin
            st_d  = StComp;
            ret_d = s_axis_tlast_i ? StPadMark : StIdle;
          end else if (s_axis_tlast_i) begin
            st_d = StPadMark;
          end
        end
      end
      StComp: if (cstat.done) st_d = ret_q;
      StPadMark: begin
        st_d = StPadZero;
        if (pos_q == LastPos) begin
          st_d  = StComp;
          ret_d = StPadZero;
        end
      end
      StPadZero: begin
        if (pos_q == PadLenPos) begin
          st_d = StPadLen;
        end else if (pos_q == LastPos) begin
          st_d  = StComp;
          ret_d = StPadZero;
        end
      end
      StPadLen: begin
        if (len_q == LastWordIdx) begin
          st_d  = StComp;
          ret_d = StOut;
        end
      end
      StOut:   if (msg_done) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // Outputs: pick the byte to place and drive the handshakes.
  always_comb begin
    put_en          = 1'b0;
    put_byte        = 8'h00;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    case (st_q)
      StIdle: begin
        s_axis_tready_o = 1'b1;
        put_en          = s_axis_tvalid_i && s_axis_tuser_i;
        put_byte        = s_axis_tdata_i;
      end
      StComp: ;
      StPadMark: begin
        put_en   = 1'b1;
        put_byte = PadMark;
      end
      StPadZero: put_en = (pos_q != PadLenPos);
      StPadLen: begin
        put_en   = 1'b1;
        put_byte = len_byte;
      end
      StOut:   m_axis_tvalid_o = 1'b1;
      default: ;
    endcase
  end

  // Every fourth byte completes a big-endian word; the last byte of a block starts a run.
  assign cmd.load   = put_en && (pos_q[1:0] == 2'b11);
  assign cmd.start  = put_en && (pos_q == LastPos);
  assign cmd.rotate = m_fire;
  assign cmd.reinit = msg_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      ret_q  <= StIdle;
      pos_q  <= '0;
      cnt_q  <= '0;
      len_q  <= '0;
      oidx_q <= '0;
    end else begin
      st_q  <= st_d;
      ret_q <= ret_d;
      if (put_en) begin
        pos_q <= pos_q + 6'd1;
      end
      if (msg_done) begin
        cnt_q <= '0;
      end else if (s_fire && s_axis_tuser_i) begin
        cnt_q <= cnt_q + {{(CountW-1){1'b0}}, 1'b1};
      end
      if (st_q == StPadLen) begin
        len_q <= len_q + 3'd1;
      end
      if (m_fire) begin
        oidx_q <= oidx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (put_en) begin
      acc_q <= {acc_q[15:0], put_byte};
    end
  end

  shamh_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .word_i   ({acc_q, put_byte}),
    .status_o (cstat),
    .digest_o (digest)
  );

  assign m_axis_tdata_o = digest;
  assign m_axis_tuser_o = oidx_q;
  assign m_axis_tlast_o = (oidx_q == LastWordIdx);

  // The length field must start exactly at byte 56 of the block.
  `SHAMH_ASSERT_NOW(a_len_at_56, (st_q == StPadLen) && (len_q == 3'd0), pos_q == PadLenPos, "length field misplaced")
  // A compression in flight keeps the core busy while the sequencer waits.
  `SHAMH_ASSERT_NOW(a_comp_busy, st_q == StComp, cstat.busy, "sequencer waits on an idle core")
  // No digest word may leave while the core still works on a block or input is taken.
  `SHAMH_ASSERT_NOW(a_out_core_idle, m_axis_tvalid_o, !cstat.busy && !s_axis_tready_o, "digest out while busy")
  // After the final digest word the hasher is back to taking bytes at block start.
  `SHAMH_ASSERT_NEXT(a_restart, msg_done, s_axis_tready_o && (pos_q == 6'd0), "no clean restart")

endmodule

[verif/sha256_message_hasher_tb.sv]
// Self-checking testbench for sha256_message_hasher: streams byte requests in,
// predicts each message digest with an independent SHA-256 model, checks words.
// Depends on the sha256_message_hasher RTL only.
`timescale 1ns / 1ps

// Predicts digests from accepted byte requests and checks the words that leave.
class digest_scoreboard;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  localparam bit [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam bit [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  bit [31:0]    chain [8];
  bit [7:0]     blk [64];
  bit [5:0]     blk_pos;
  bit [60:0]    byte_count;
  digest_word_t pending_words [$];
  int           errors;

  function new();
    chain      = IV_TAB;
    blk_pos    = '0;
    byte_count = '0;
    errors     = 0;
  endfunction

  function automatic bit [31:0] rotr(bit [31:0] x, int r);
    return (x >> r) | (x << (32 - r));
  endfunction

  // Run the 64 rounds on the buffered block and fold into the chain.
  function void compress();
    bit [31:0] w [64];
    bit [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + K_TAB[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endfunction

  function void absorb(bit [7:0] value);
    blk[blk_pos] = value;
    blk_pos++;
    if (blk_pos == 0) compress();
  endfunction

  // Note one accepted request; a message end queues the eight digest words.
  function void note_request(logic [7:0] value, logic has_byte, logic ends_msg);
    bit [63:0]    bit_len;
    digest_word_t dw;
    if (has_byte) begin
      absorb(value);
      byte_count++;
    end
    if (!ends_msg) return;
    bit_len = {byte_count, 3'b000};
    absorb(8'h80);
    while (blk_pos != 6'd56) absorb(8'h00);
    for (int i = 0; i < 8; i++) absorb(bit_len[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      dw.word = chain[i];
      dw.idx  = i[2:0];
      dw.last = (i == 7);
      pending_words.push_back(dw);
    end
    chain      = IV_TAB;
    byte_count = '0;
    blk_pos    = '0;
  endfunction

  task report_mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_word(logic [31:0] word, logic [2:0] idx, logic last);
    digest_word_t dw;
    if (pending_words.size() == 0) begin
      report_mismatch($sformatf("digest word %h idx %0d with no message ended", word, idx));
      return;
    end
    dw = pending_words.pop_front();
    if (word !== dw.word)
      report_mismatch($sformatf("word %0d: got %h, want %h", dw.idx, word, dw.word));
    if (idx !== dw.idx)
      report_mismatch($sformatf("word index: got %0d, want %0d", idx, dw.idx));
    if (last !== dw.last)
      report_mismatch($sformatf("word %0d last flag: got %b, want %b", dw.idx, last, dw.last));
  endtask

  function int words_pending();
    return pending_words.size();
  endfunction

endclass

module sha256_message_hasher_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int ITEM_TARGET = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] message_byte
  logic        s_axis_tuser_i;   // [0] carries_byte
  logic        s_axis_tlast_i;   // end_of_message
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [31:0] digest_word
  logic [2:0]  m_axis_tuser_o;   // [2:0] word_index
  logic        m_axis_tlast_o;   // last_word

  digest_scoreboard sb;
  int               cycle_count;
  int               item_count;
  bit               calm;        // high: both sides run without idling

  sha256_message_hasher dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Abort on a hang: a lost request or a digest that never leaves.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Watch both handshakes at the rising edge; inputs settled at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_request(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_word(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  // Alternate between random-gap and full-rate stretches.
  initial begin
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(150, 700)) @(negedge clk_i);
      calm = ~calm;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Offer one request after a random gap; hold it until accepted.
  // Called at a falling edge and returns at one; tvalid stays high for a back-to-back request.
  task send_request(input logic [7:0] value, input logic has_byte, input logic ends_msg);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i  = value;
    s_axis_tuser_i  = has_byte;
    s_axis_tlast_i  = ends_msg;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    item_count++;
  endtask

  // Send a message of random bytes with stray no-op requests mixed in. The end either
  // rides on the last byte or comes as a separate empty request.
  task send_message(input int len);
    bit fold;
    fold = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_request(8'($urandom_range(0, 255)), 1'b1, fold && (k == len - 1));
    end
    if (!fold) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Digest receiver: stall a random number of cycles once a word is offered.
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        m_axis_tready_i = 1'b0;
        do @(posedge clk_i); while (!m_axis_tvalid_o);
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    int len;
    sb              = new();
    cycle_count     = 0;
    item_count      = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tlast_i  = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty message from a bare end request (byte lane must be ignored).
    send_request(8'ha5, 1'b0, 1'b1);
    // One-byte messages at the byte extremes, end riding on the byte.
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    // Requests with neither flag before and between real bytes, then an empty end.
    send_request(8'h5a, 1'b0, 1'b0);
    send_request(8'hc3, 1'b1, 1'b0);
    send_request(8'h3c, 1'b0, 1'b0);
    send_request(8'h81, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b1);
    // The classic three-letter message.
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);

    // A 56-byte message forces a second padding block.
    send_message(56);

    // Random messages up to the item budget: mostly short, some near a block boundary.
    // Trim a long draw to what the budget has left.
    while (item_count < ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0:       len = 56 + 64 * $urandom_range(0, 1);
        1:       len = 55 + $urandom_range(0, 10);
        default: len = $urandom_range(0, 12);
      endcase
      if (len > ITEM_TARGET - item_count) len = ITEM_TARGET - item_count;
      send_message(len);
    end
    s_axis_tvalid_i = 1'b0;

    // Drain the outstanding digests, then give stray words time to show up.
    while (sb.words_pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/shamh_pkg.sv
design/shamh_core.sv
design/sha256_message_hasher.sv
verif/sha256_message_hasher_tb.sv
